FILE: rtl/glyph_row_scaler_assert.svh
// ----------------------------------------------------------------------------
// Glyph row scaler assertion macros
// Shared concurrent assertion forms used by the scaler RTL.
// ----------------------------------------------------------------------------
`ifndef GLYPH_ROW_SCALER_ASSERT_SVH
`define GLYPH_ROW_SCALER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glyph row scaler: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glyph row scaler: next-cycle check failed");

`endif

FILE: rtl/grs_pkg.sv
// ----------------------------------------------------------------------------
// Glyph row scaler package
// Constants, shared types and the row widening function.
// ----------------------------------------------------------------------------
package grs_pkg;

    localparam int MAX_SCALE    = 4;
    localparam int SCREEN_WIDTH = 240;
    localparam int GLYPH_SIZE   = 8;

    localparam int COORD_W    = 12;
    localparam int SCALE_W    = 3;
    localparam int REQ_W      = 4;
    localparam int COLOR_W    = 16;
    localparam int TLEN_W     = 8;
    localparam int ROW_W      = 8;
    localparam int ROW_IDX_W  = 3;
    localparam int MASK_W     = 32;
    localparam int WIDTH_W    = 6;
    localparam int LINE_CNT_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X       = 3'd0,
        REG_START_Y       = 3'd1,
        REG_SCALE_REQUEST = 3'd2,
        REG_FG_COLOR      = 3'd3,
        REG_BG_COLOR      = 3'd4,
        REG_CENTER_MODE   = 3'd5,
        REG_TEXT_LENGTH   = 3'd6
    } cfg_reg_t;

    // Register values plus the two figures derived from them.
    typedef struct packed {
        logic [COORD_W-1:0] start_y;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic [SCALE_W-1:0] scale;
        logic [COORD_W-1:0] first_col;
    } cfg_t;

    // Everything the line emitter needs for one glyph row.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W:0]   y_base;
        logic [SCALE_W-1:0] scale;
        logic [MASK_W-1:0]  mask;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
    } desc_t;

    // Repeats every glyph pixel scale times; bit 0 stays the leftmost pixel.
    function automatic logic [MASK_W-1:0] widen_row(input logic [ROW_W-1:0] bits,
                                                    input logic [SCALE_W-1:0] scale);
        logic [MASK_W-1:0] mask;
        int pos;
        mask = '0;
        for (int col = 0; col < ROW_W; col++) begin
            for (int k = 0; k < MAX_SCALE; k++) begin
                pos = col * int'(scale) + k;
                if (bits[col] && (k < int'(scale)) && (pos < MASK_W)) begin
                    mask[pos] = 1'b1;
                end
            end
        end
        return mask;
    endfunction

endpackage

FILE: rtl/grs_row_if.sv
// ----------------------------------------------------------------------------
// Glyph row channel
// Carries one glyph row and the new-text flag per beat.
// ----------------------------------------------------------------------------
interface grs_row_if;
    logic                       valid;
    logic                       ready;
    logic [grs_pkg::ROW_W-1:0]  row_bits;
    logic                       new_text;

    modport source (output valid, output row_bits, output new_text, input ready);
    modport sink   (input valid, input row_bits, input new_text, output ready);
endinterface

FILE: rtl/grs_line_if.sv
// ----------------------------------------------------------------------------
// Screen line channel
// Carries one scaled screen line per beat.
// ----------------------------------------------------------------------------
interface grs_line_if;
    logic                          valid;
    logic                          ready;
    logic [grs_pkg::COORD_W-1:0]   line_x;
    logic [grs_pkg::COORD_W-1:0]   line_y;
    logic [grs_pkg::WIDTH_W-1:0]   line_width;
    logic [grs_pkg::MASK_W-1:0]    pixel_mask;
    logic [grs_pkg::COLOR_W-1:0]   fg_out;
    logic [grs_pkg::COLOR_W-1:0]   bg_out;
    logic                          last_line;

    modport source (output valid, output line_x, output line_y, output line_width,
                    output pixel_mask, output fg_out, output bg_out, output last_line,
                    input ready);
    modport sink   (input valid, input line_x, input line_y, input line_width,
                    input pixel_mask, input fg_out, input bg_out, input last_line,
                    output ready);
endinterface

FILE: rtl/grs_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data per beat.
// ----------------------------------------------------------------------------
interface grs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [grs_pkg::CFG_IDX_W-1:0]    idx;
    logic [grs_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

FILE: rtl/grs_cfg_regs.sv
// ----------------------------------------------------------------------------
// Glyph row scaler configuration registers
// Register file plus effective scale and centered first column.
// ----------------------------------------------------------------------------
module grs_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    grs_cfg_if.sink       cfg,
    output grs_pkg::cfg_t cfg_out
);
    import grs_pkg::*;

    logic [COORD_W-1:0] start_x_reg;
    logic [COORD_W-1:0] start_y_reg;
    logic [REQ_W-1:0]   scale_req_reg;
    logic [COLOR_W-1:0] fg_color_reg;
    logic [COLOR_W-1:0] bg_color_reg;
    logic               center_mode_reg;
    logic [TLEN_W-1:0]  text_length_reg;

    logic [TLEN_W+REQ_W-1:0]   chars_x_scale;
    logic [TLEN_W+REQ_W+2:0]   text_width;
    logic [TLEN_W+REQ_W+2:0]   free_width;
    logic [COORD_W-1:0]        center_col;
    logic [SCALE_W-1:0]        eff_scale;

    localparam logic [TLEN_W+REQ_W+2:0] SCREEN_W_C = (TLEN_W+REQ_W+3)'(SCREEN_WIDTH);

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            scale_req_reg   <= REQ_W'(1);
            fg_color_reg    <= {COLOR_W{1'b1}};
            bg_color_reg    <= '0;
            center_mode_reg <= 1'b0;
            text_length_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.idx))
                REG_START_X:       start_x_reg     <= cfg.data[COORD_W-1:0];
                REG_START_Y:       start_y_reg     <= cfg.data[COORD_W-1:0];
                REG_SCALE_REQUEST: scale_req_reg   <= cfg.data[REQ_W-1:0];
                REG_FG_COLOR:      fg_color_reg    <= cfg.data[COLOR_W-1:0];
                REG_BG_COLOR:      bg_color_reg    <= cfg.data[COLOR_W-1:0];
                REG_CENTER_MODE:   center_mode_reg <= cfg.data[0];
                REG_TEXT_LENGTH:   text_length_reg <= cfg.data[TLEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Centering uses the raw requested scale, even when it is zero or too large.
    always_comb
    begin
        chars_x_scale = text_length_reg * scale_req_reg;
        text_width    = {chars_x_scale, 3'b000};
        free_width    = SCREEN_W_C - text_width;
        if (text_width >= SCREEN_W_C)
        begin
            center_col = '0;
        end
        else
        begin
            center_col = COORD_W'(free_width >> 1);
        end
    end

    always_comb
    begin
        priority if (scale_req_reg == '0)
        begin
            eff_scale = SCALE_W'(1);
        end
        else if (scale_req_reg > REQ_W'(MAX_SCALE))
        begin
            eff_scale = SCALE_W'(MAX_SCALE);
        end
        else
        begin
            eff_scale = scale_req_reg[SCALE_W-1:0];
        end
    end

    assign cfg_out.start_y   = start_y_reg;
    assign cfg_out.fg_color  = fg_color_reg;
    assign cfg_out.bg_color  = bg_color_reg;
    assign cfg_out.scale     = eff_scale;
    assign cfg_out.first_col = center_mode_reg ? center_col : start_x_reg;

endmodule

FILE: rtl/grs_row_unit.sv
// ----------------------------------------------------------------------------
// Glyph row scaler row unit
// Holds the cursor and row counter and builds a row descriptor per beat.
// ----------------------------------------------------------------------------
module grs_row_unit (
    input  logic           clk,
    input  logic           rst_n,
    grs_row_if.sink        glyph,
    input  grs_pkg::cfg_t  cfg_in,
    output grs_pkg::desc_t desc,
    output logic           desc_valid,
    input  logic           desc_ready
);
    import grs_pkg::*;

    logic [COORD_W-1:0]   cursor_reg;
    logic [COORD_W-1:0]   cursor_next;
    logic [ROW_IDX_W-1:0] row_reg;
    logic [ROW_IDX_W-1:0] row_next;

    logic [COORD_W-1:0]   cur_x;
    logic [ROW_IDX_W-1:0] cur_row;
    logic [COORD_W:0]     advanced;
    logic                 accept;

    assign glyph.ready = desc_ready;
    assign desc_valid  = glyph.valid;
    assign accept      = glyph.valid && desc_ready;

    always_comb
    begin
        cur_x   = glyph.new_text ? cfg_in.first_col : cursor_reg;
        cur_row = glyph.new_text ? '0 : row_reg;

        advanced = {1'b0, cur_x} + (COORD_W+1)'({cfg_in.scale, 3'b000});

        row_next    = cur_row + ROW_IDX_W'(1);
        cursor_next = cur_x;
        if (cur_row == ROW_IDX_W'(GLYPH_SIZE - 1))
        begin
            cursor_next = advanced[COORD_W] ? COORD_MAX : advanced[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            row_reg    <= '0;
        end
        else if (accept)
        begin
            cursor_reg <= cursor_next;
            row_reg    <= row_next;
        end
    end

    assign desc.x      = cur_x;
    assign desc.y_base = {1'b0, cfg_in.start_y}
                         + ((COORD_W+1)'(cur_row) * (COORD_W+1)'(cfg_in.scale));
    assign desc.scale  = cfg_in.scale;
    assign desc.mask   = widen_row(glyph.row_bits, cfg_in.scale);
    assign desc.fg     = cfg_in.fg_color;
    assign desc.bg     = cfg_in.bg_color;

endmodule

FILE: rtl/grs_line_emitter.sv
// ----------------------------------------------------------------------------
// Glyph row scaler line emitter
// Holds one row descriptor and sends its replicated lines, one per cycle while lines is ready.
// ----------------------------------------------------------------------------
module grs_line_emitter (
    input  logic           clk,
    input  logic           rst_n,
    input  grs_pkg::desc_t desc,
    input  logic           desc_valid,
    output logic           desc_ready,
    grs_line_if.source     lines
);
    import grs_pkg::*;

    `include "glyph_row_scaler_assert.svh"

    desc_t                 desc_reg;
    logic                  desc_valid_reg;
    logic [LINE_CNT_W-1:0] line_cnt_reg;

    logic                  out_valid_reg;
    logic [COORD_W-1:0]    out_x_reg;
    logic [COORD_W-1:0]    out_y_reg;
    logic [WIDTH_W-1:0]    out_width_reg;
    logic [MASK_W-1:0]     out_mask_reg;
    logic [COLOR_W-1:0]    out_fg_reg;
    logic [COLOR_W-1:0]    out_bg_reg;
    logic                  out_last_reg;

    logic                  load_line;
    logic                  line_is_last;
    logic [COORD_W:0]      y_sum;
    logic [COORD_W-1:0]    y_sat;

    assign load_line    = desc_valid_reg && (!out_valid_reg || lines.ready);
    assign line_is_last = (SCALE_W'(line_cnt_reg) == desc_reg.scale - SCALE_W'(1));
    // A new row may enter in the same cycle the held one sends its last line.
    assign desc_ready   = !desc_valid_reg || (load_line && line_is_last);

    assign y_sum = desc_reg.y_base + (COORD_W+1)'(line_cnt_reg);
    assign y_sat = y_sum[COORD_W] ? COORD_MAX : y_sum[COORD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
            line_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (desc_ready)
            begin
                desc_valid_reg <= desc_valid;
            end
            if (load_line)
            begin
                line_cnt_reg <= line_is_last ? '0 : line_cnt_reg + LINE_CNT_W'(1);
            end
            if (load_line)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (lines.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_ready && desc_valid)
        begin
            desc_reg <= desc;
        end
        if (load_line)
        begin
            out_x_reg     <= desc_reg.x;
            out_y_reg     <= y_sat;
            out_width_reg <= WIDTH_W'({desc_reg.scale, 3'b000});
            out_mask_reg  <= desc_reg.mask;
            out_fg_reg    <= desc_reg.fg;
            out_bg_reg    <= desc_reg.bg;
            out_last_reg  <= line_is_last;
        end
    end

    assign lines.valid      = out_valid_reg;
    assign lines.line_x     = out_x_reg;
    assign lines.line_y     = out_y_reg;
    assign lines.line_width = out_width_reg;
    assign lines.pixel_mask = out_mask_reg;
    assign lines.fg_out     = out_fg_reg;
    assign lines.bg_out     = out_bg_reg;
    assign lines.last_line  = out_last_reg;

    `GRS_ASSERT_SAME(a_cnt_in_range, clk, rst_n, desc_valid_reg, SCALE_W'(line_cnt_reg) < desc_reg.scale)
    `GRS_ASSERT_NEXT(a_hold_when_stalled, clk, rst_n, desc_valid_reg && !load_line, desc_valid_reg && $stable(line_cnt_reg))
    `GRS_ASSERT_NEXT(a_row_kept_midway, clk, rst_n, load_line && !line_is_last, desc_valid_reg && line_cnt_reg != '0)
    `GRS_ASSERT_NEXT(a_last_ends_row, clk, rst_n, load_line && line_is_last, line_cnt_reg == '0 && out_last_reg)

endmodule

FILE: rtl/glyph_row_scaler.sv
// ----------------------------------------------------------------------------
// Glyph row scaler
// Expands 8-pixel glyph rows by the scale and emits one screen line per beat.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  glyph    in         row_bits, new_text
//  lines    out        line_x, line_y, line_width, pixel_mask, fg_out, bg_out, last_line
//  cfg      in         idx, data (register write, always ready)
//
//  A row accepted from glyph is held in the descriptor register; its s lines (s is
//  the scale, 1 to 4) then enter the output register one per cycle while lines is
//  ready. The next row is taken at the edge that moves its predecessor's last line
//  into the output register.
//  A stall on lines holds the output register and, behind it, the descriptor.
//  Reset clears the cursor, row counter and all valid flags.
// ----------------------------------------------------------------------------
module glyph_row_scaler (
    input  logic        clk,
    input  logic        rst_n,
    grs_row_if.sink     glyph,
    grs_line_if.source  lines,
    grs_cfg_if.sink     cfg
);
    import grs_pkg::*;

    cfg_t  cfg_val;
    desc_t desc;
    logic  desc_valid;
    logic  desc_ready;

    grs_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    grs_row_unit u_row_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .glyph      (glyph),
        .cfg_in     (cfg_val),
        .desc       (desc),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready)
    );

    grs_line_emitter u_line_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (desc),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .lines      (lines)
    );

endmodule

FILE: verif/glyph_row_scaler_test.sv
// ----------------------------------------------------------------------------
// Glyph row scaler testbench
// Feeds glyph rows and register writes to the scaler and checks every screen
// line against a cycle-free prediction of cursor, row counter and widening.
// ----------------------------------------------------------------------------
module glyph_row_scaler_test;

    timeunit 1ns;
    timeprecision 1ps;

    import grs_pkg::*;

    localparam int RANDOM_ROWS    = 450;
    localparam int QUIET_TAIL     = 70;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [WIDTH_W-1:0] width;
        logic [MASK_W-1:0]  mask;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic               last;
    } screen_line_t;

    logic clk;
    logic rst_n;

    grs_row_if  glyph();
    grs_line_if lines();
    grs_cfg_if  cfg();

    glyph_row_scaler i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .glyph (glyph),
        .lines (lines),
        .cfg   (cfg)
    );

    // Register copies and text state as the scaler should hold them.
    logic [COORD_W-1:0]   reg_start_x;
    logic [COORD_W-1:0]   reg_start_y;
    logic [REQ_W-1:0]     reg_scale_req;
    logic [COLOR_W-1:0]   reg_fg;
    logic [COLOR_W-1:0]   reg_bg;
    logic                 reg_center;
    logic [TLEN_W-1:0]    reg_text_len;
    logic [COORD_W-1:0]   cursor_col;
    logic [ROW_IDX_W-1:0] glyph_row;

    screen_line_t pending_lines[$];
    int  failures;
    int  rows_sent;
    int  stall_left;
    int  idle_cycles;
    bit  gaps_on;

    always #5 clk = ~clk;

    function automatic int draw_scale();
        if (reg_scale_req == 0)
            return 1;
        if (int'(reg_scale_req) > MAX_SCALE)
            return MAX_SCALE;
        return int'(reg_scale_req);
    endfunction

    // Centering uses the raw requested scale, not the clamped one.
    function automatic logic [COORD_W-1:0] text_origin();
        int w;
        int x;
        if (!reg_center)
            return reg_start_x;
        w = int'(reg_text_len) * GLYPH_SIZE * int'(reg_scale_req);
        x = (SCREEN_WIDTH - w) / 2;
        if (x < 0)
            x = 0;
        if (x > int'(COORD_MAX))
            x = int'(COORD_MAX);
        return x[COORD_W-1:0];
    endfunction

    task automatic predict_lines(input logic [ROW_W-1:0] bits, input logic restart);
        screen_line_t ln;
        logic [MASK_W-1:0] wide;
        int s;
        int y;
        int adv;
        if (restart)
        begin
            cursor_col = text_origin();
            glyph_row  = '0;
        end
        s    = draw_scale();
        wide = '0;
        for (int col = 0; col < ROW_W; col++)
        begin
            for (int k = 0; k < s; k++)
            begin
                if (bits[col] && (col * s + k < MASK_W))
                    wide[col * s + k] = 1'b1;
            end
        end
        for (int k = 0; k < s; k++)
        begin
            y = int'(reg_start_y) + int'(glyph_row) * s + k;
            if (y > int'(COORD_MAX))
                y = int'(COORD_MAX);
            ln.x     = cursor_col;
            ln.y     = y[COORD_W-1:0];
            ln.width = WIDTH_W'(8 * s);
            ln.mask  = wide;
            ln.fg    = reg_fg;
            ln.bg    = reg_bg;
            ln.last  = (k == s - 1);
            pending_lines.push_back(ln);
        end
        if (glyph_row == ROW_IDX_W'(GLYPH_SIZE - 1))
        begin
            glyph_row = '0;
            adv = int'(cursor_col) + GLYPH_SIZE * s;
            cursor_col = (adv > int'(COORD_MAX)) ? COORD_MAX : adv[COORD_W-1:0];
        end
        else
        begin
            glyph_row = glyph_row + 1'b1;
        end
    endtask

    task automatic compare_field(input string field, input logic [MASK_W-1:0] want,
                                 input logic [MASK_W-1:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    // Line sink: checks each beat and, while gaps are on, stalls in random bursts.
    always @(posedge clk)
    begin
        screen_line_t want;
        logic ready_next;
        if (rst_n && lines.valid && lines.ready)
        begin
            if (pending_lines.size() == 0)
            begin
                failures++;
                $display("%0t ns: unexpected line, expected none, actual x=0x%0h y=0x%0h",
                         $time, lines.line_x, lines.line_y);
            end
            else
            begin
                want = pending_lines.pop_front();
                compare_field("line_x", MASK_W'(want.x), MASK_W'(lines.line_x));
                compare_field("line_y", MASK_W'(want.y), MASK_W'(lines.line_y));
                compare_field("line_width", MASK_W'(want.width), MASK_W'(lines.line_width));
                compare_field("pixel_mask", want.mask, lines.pixel_mask);
                compare_field("fg_out", MASK_W'(want.fg), MASK_W'(lines.fg_out));
                compare_field("bg_out", MASK_W'(want.bg), MASK_W'(lines.bg_out));
                compare_field("last_line", MASK_W'(want.last), MASK_W'(lines.last_line));
            end
        end
        ready_next = 1'b1;
        if (gaps_on && stall_left > 0)
        begin
            stall_left--;
            ready_next = 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            ready_next = 1'b0;
        end
        lines.ready <= ready_next;
    end

    always @(posedge clk)
    begin
        if ((glyph.valid && glyph.ready) || (lines.valid && lines.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("glyph_row_scaler test failed");
            $finish;
        end
    end

    // Leaves valid high after the beat so that back-to-back rows need no gap.
    task automatic send_row(input logic [ROW_W-1:0] bits, input logic restart);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            glyph.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        glyph.valid    <= 1'b1;
        glyph.row_bits <= bits;
        glyph.new_text <= restart;
        do @(posedge clk); while (glyph.ready !== 1'b1);
        predict_lines(bits, restart);
        rows_sent++;
    endtask

    // Stops the row stream and waits until every predicted line has left.
    task automatic settle();
        glyph.valid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.idx   <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (cfg.ready !== 1'b1);
        case (idx)
            REG_START_X:       reg_start_x   = value[COORD_W-1:0];
            REG_START_Y:       reg_start_y   = value[COORD_W-1:0];
            REG_SCALE_REQUEST: reg_scale_req = value[REQ_W-1:0];
            REG_FG_COLOR:      reg_fg        = value[COLOR_W-1:0];
            REG_BG_COLOR:      reg_bg        = value[COLOR_W-1:0];
            REG_CENTER_MODE:   reg_center    = value[0];
            REG_TEXT_LENGTH:   reg_text_len  = value[TLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        cfg.valid <= 1'b0;
    endtask

    // Rows straight after reset run on the reset register values.
    task automatic test_defaults();
        send_row(8'h00, 1'b0);
        send_row(8'hFF, 1'b0);
        send_row(8'h01, 1'b0);
        settle();
    endtask

    task automatic test_scale_clamp();
        write_reg(REG_FG_COLOR, 16'h0000);
        write_reg(REG_BG_COLOR, 16'hFFFF);
        write_reg(REG_SCALE_REQUEST, 16'd0);
        end_writes();
        send_row(8'h80, 1'b1);
        send_row(8'h55, 1'b0);
        settle();
        write_reg(REG_SCALE_REQUEST, 16'd3);
        end_writes();
        send_row(8'hAA, 1'b0);
        send_row(8'h7E, 1'b0);
        settle();
        write_reg(REG_SCALE_REQUEST, 16'd15);
        end_writes();
        send_row(8'hFF, 1'b0);
        send_row(8'h01, 1'b0);
        settle();
    endtask

    task automatic test_centering();
        write_reg(REG_CENTER_MODE, 16'd1);
        write_reg(REG_TEXT_LENGTH, 16'd3);
        write_reg(REG_SCALE_REQUEST, 16'd2);
        end_writes();
        send_row(8'hC3, 1'b1);
        settle();
        write_reg(REG_TEXT_LENGTH, 16'd255);
        write_reg(REG_SCALE_REQUEST, 16'd15);
        end_writes();
        send_row(8'h3C, 1'b1);
        settle();
        write_reg(REG_TEXT_LENGTH, 16'd0);
        end_writes();
        send_row(8'h81, 1'b1);
        settle();
        // A raw request of zero gives zero text width although it draws at one.
        write_reg(REG_TEXT_LENGTH, 16'd5);
        write_reg(REG_SCALE_REQUEST, 16'd0);
        end_writes();
        send_row(8'h18, 1'b1);
        settle();
    endtask

    // The ninth row shows the cursor pinned at COORD_MAX.
    task automatic test_saturation();
        logic [ROW_W-1:0] pattern [9];
        pattern = '{8'hFF, 8'h00, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'hFF};
        write_reg(REG_CENTER_MODE, 16'd0);
        write_reg(REG_START_X, 16'd4090);
        write_reg(REG_START_Y, 16'd4090);
        write_reg(REG_SCALE_REQUEST, 16'd4);
        end_writes();
        for (int i = 0; i < 9; i++)
            send_row(pattern[i], i == 0);
        settle();
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd4095;
            2: return 16'($urandom_range(4050, 4095));
            default: return 16'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic randomize_regs();
        if ($urandom_range(0, 1)) write_reg(REG_START_X, pick_coord());
        if ($urandom_range(0, 1)) write_reg(REG_START_Y, pick_coord());
        if ($urandom_range(0, 1))
            write_reg(REG_SCALE_REQUEST, ($urandom_range(0, 3) == 0) ?
                      16'($urandom_range(0, 15)) : 16'($urandom_range(1, 4)));
        if ($urandom_range(0, 2) == 0) write_reg(REG_FG_COLOR, 16'($urandom));
        if ($urandom_range(0, 2) == 0) write_reg(REG_BG_COLOR, 16'($urandom));
        if ($urandom_range(0, 1)) write_reg(REG_CENTER_MODE, 16'($urandom_range(0, 1)));
        if ($urandom_range(0, 1))
            write_reg(REG_TEXT_LENGTH, $urandom_range(0, 1) ?
                      16'($urandom_range(0, 255)) : 16'($urandom_range(0, 31)));
        end_writes();
    endtask

    // Batches of up to 40 rows, mostly each a new text; now and then a restart lands
    // mid-character or a setting change lands inside a text.
    task automatic test_random_text();
        int goal;
        int count;
        logic restart;
        logic [ROW_W-1:0] bits;
        goal = rows_sent + RANDOM_ROWS;
        while (rows_sent < goal)
        begin
            settle();
            gaps_on = (goal - rows_sent > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            randomize_regs();
            count = $urandom_range(8, 40);
            if (count > goal - rows_sent)
                count = goal - rows_sent;
            for (int i = 0; i < count; i++)
            begin
                restart = (i == 0) ? ($urandom_range(0, 4) != 0) : 1'b0;
                if ($urandom_range(0, 15) == 0)
                    restart = ~restart;
                case ($urandom_range(0, 7))
                    0: bits = 8'h00;
                    1: bits = 8'hFF;
                    default: bits = 8'($urandom_range(0, 255));
                endcase
                send_row(bits, restart);
            end
        end
        gaps_on = 1'b0;
        settle();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        glyph.valid    = 1'b0;
        glyph.row_bits = '0;
        glyph.new_text = 1'b0;
        lines.ready    = 1'b0;
        cfg.valid      = 1'b0;
        cfg.idx        = REG_START_X;
        cfg.data       = '0;
        reg_start_x    = '0;
        reg_start_y    = '0;
        reg_scale_req  = 4'd1;
        reg_fg         = 16'hFFFF;
        reg_bg         = '0;
        reg_center     = 1'b0;
        reg_text_len   = '0;
        cursor_col     = '0;
        glyph_row      = '0;
        failures       = 0;
        rows_sent      = 0;
        stall_left     = 0;
        idle_cycles    = 0;
        gaps_on        = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_scale_clamp();
        test_centering();
        test_saturation();
        test_random_text();

        repeat (16) @(posedge clk);
        if (pending_lines.size() != 0)
        begin
            failures++;
            $display("%0t ns: lines missing, expected %0d more, actual 0",
                     $time, pending_lines.size());
        end
        if (failures == 0)
            $display("glyph_row_scaler test passed");
        else
            $display("glyph_row_scaler test failed");
        $finish;
    end

endmodule
